[hw/rtl/fnms_pkg.sv]
`timescale 1ns / 1ps

package fnms_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;

  localparam logic [15:0] MAT_INDEX_RST = 16'd6144;

  // Q1.16 reflectance of one
  localparam logic [16:0] KR_ONE = 17'd65536;

  // cosine and sine are Q0.24 carried in 25 bits
  localparam int unsigned CW = 25;
  localparam logic [CW-1:0] ONE_Q24 = 25'h100_0000;

  // one in Q0.48, radicand width of the sine and cosine roots
  localparam int unsigned SQW = 50;
  localparam logic [SQW-1:0] ONE_Q48 = 50'h1_0000_0000_0000;

  // Fresnel ratios are Q0.22 carried in 23 bits
  localparam int unsigned RBW = 23;
  localparam logic [RBW-1:0] RATIO_ONE = 23'h40_0000;

endpackage

[hw/rtl/fnms_isqrt.sv]
`timescale 1ns / 1ps

module fnms_isqrt #(
  parameter int unsigned XW = 62,
  parameter int unsigned SW = 1,
  localparam int unsigned RW = XW / 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] root_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [RW];
  logic [XW-1:0] x_q    [RW];
  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar i = 0; i < RW; i++) begin : g_st
    logic          v_p;
    logic [XW-1:0] x_p;
    logic [RW:0]   rem_p;
    logic [RW-1:0] root_p;
    logic [SW-1:0] s_p;
    logic [RW+2:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+2:0] diff;
    logic          take;

    if (i == 0) begin : g_first
      assign v_p    = valid_i;
      assign x_p    = x_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign s_p    = side_i;
    end else begin : g_next
      assign v_p    = v_q[i-1];
      assign x_p    = x_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign root_p = root_q[i-1];
      assign s_p    = side_q[i-1];
    end

    assign rem_sh = {rem_p, x_p[XW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign diff   = rem_sh - {1'b0, trial};
    assign take   = rem_sh >= {1'b0, trial};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_p << 2;
        rem_q[i]  <= take ? diff[RW:0] : rem_sh[RW:0];
        root_q[i] <= {root_p[RW-2:0], take};
        side_q[i] <= s_p;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

[hw/rtl/fnms_div.sv]
`timescale 1ns / 1ps

module fnms_div #(
  parameter int unsigned NW = 41,
  parameter int unsigned DW = 16,
  parameter int unsigned QB = 25,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  // caller guarantees num_i < den_i * 2^QB or discards the quotient
  logic [NW-1:0] num_hi;
  assign num_hi = num_i >> QB;

  logic          v_q    [QB];
  logic [QB-1:0] lo_q   [QB];
  logic [DW-1:0] rem_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic [QB-1:0] quot_q [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic          v_p;
    logic [QB-1:0] lo_p;
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QB-1:0] quot_p;
    logic [SW-1:0] s_p;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign v_p    = valid_i;
      assign lo_p   = num_i[QB-1:0];
      assign rem_p  = num_hi[DW-1:0];
      assign den_p  = den_i;
      assign quot_p = '0;
      assign s_p    = side_i;
    end else begin : g_next
      assign v_p    = v_q[i-1];
      assign lo_p   = lo_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign den_p  = den_q[i-1];
      assign quot_p = quot_q[i-1];
      assign s_p    = side_q[i-1];
    end

    assign rem_sh = {rem_p, lo_p[QB-1]};
    assign diff   = rem_sh - {1'b0, den_p};
    assign take   = rem_sh >= {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[i]   <= lo_p << 1;
        rem_q[i]  <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
        den_q[i]  <= den_p;
        quot_q[i] <= {quot_p[QB-2:0], take};
        side_q[i] <= s_p;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = quot_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

[hw/rtl/fresnel_normal_mapped_select_top.sv]
`timescale 1ns / 1ps
// throughput: one request per cycle while the output is not stalled;
// the bit-per-stage root and divide pipelines set the depth
// a stalled result freezes the whole pipeline in place, nothing is dropped or repeated
// reset clears all valid bits and sets material_index to 1.5 (6144)
module fresnel_normal_mapped_select_top #(
  parameter int unsigned FRAC_BITS = fnms_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] normal_vec_i,
  input  logic [47:0] tangent_vec_i,
  input  logic [47:0] map_sample_i,
  input  logic [47:0] ray_dir_i,
  input  logic [15:0] outside_index_i,
  input  logic [15:0] random_draw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        choose_reflected_o,
  output logic [16:0] reflectance_o,
  output logic        total_internal_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned PW  = (FRAC_BITS + 34 > 50) ? FRAC_BITS + 34 : 50;
  localparam int unsigned PPW = PW + 1;
  localparam int unsigned NSH = $clog2(PW);
  localparam int unsigned CSH = 24 - FRAC_BITS;
  localparam int unsigned CNW = 48 + CSH;
  localparam int unsigned CW  = fnms_pkg::CW;
  localparam int unsigned SQW = fnms_pkg::SQW;
  localparam int unsigned RBW = fnms_pkg::RBW;

  logic pipe_en;
  logic out_valid_q;
  logic [15:0] material_index_q;

  assign pipe_en     = !out_valid_q || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      material_index_q <= fnms_pkg::MAT_INDEX_RST;
    end else if (cfg_valid_i) begin
      material_index_q <= cfg_data_i;
    end
  end

  // ---------------- unpack and cross product ----------------
  logic signed [15:0] in_n [3];
  logic signed [15:0] in_t [3];
  logic signed [17:0] in_w [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_n[k] = $signed(normal_vec_i[16*k +: 16]);
      in_t[k] = $signed(tangent_vec_i[16*k +: 16]);
      in_w[k] = $signed({1'b0, map_sample_i[16*k +: 16], 1'b0}) - 18'sd65536;
    end
  end

  // sideband: {ray, etai, draw}
  logic               s1_v_q;
  logic signed [31:0] s1_pa_q [3];
  logic signed [31:0] s1_pb_q [3];
  logic signed [15:0] s1_n_q  [3];
  logic signed [15:0] s1_t_q  [3];
  logic signed [17:0] s1_w_q  [3];
  logic [79:0]        s1_sb_q;

  logic               s2_v_q;
  logic signed [32:0] s2_b_q  [3];
  logic signed [33:0] s2_tw_q [3];
  logic signed [33:0] s2_nw_q [3];
  logic signed [17:0] s2_w1_q;
  logic [79:0]        s2_sb_q;

  logic               s3_v_q;
  logic signed [50:0] s3_bw_q [3];
  logic signed [34:0] s3_tn_q [3];
  logic [79:0]        s3_sb_q;

  logic                s4_v_q;
  logic signed [PW:0]  s4_p_q [3];
  logic [79:0]         s4_sb_q;

  logic          s5_v_q;
  logic [PW-1:0] s5_m_q [3];
  logic [2:0]    s5_neg_q;
  logic [79:0]   s5_sb_q;

  logic          s6_v_q;
  logic [PW-1:0] s6_m_q [3];
  logic [PW-1:0] s6_mx_q;
  logic [2:0]    s6_neg_q;
  logic [79:0]   s6_sb_q;

  logic [PW-1:0] mx01;
  logic [PW-1:0] mx_all;
  assign mx01   = (s5_m_q[0] > s5_m_q[1]) ? s5_m_q[0] : s5_m_q[1];
  assign mx_all = (mx01 > s5_m_q[2]) ? mx01 : s5_m_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (pipe_en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_pa_q[0] <= in_n[1] * in_t[2];
      s1_pb_q[0] <= in_n[2] * in_t[1];
      s1_pa_q[1] <= in_n[2] * in_t[0];
      s1_pb_q[1] <= in_n[0] * in_t[2];
      s1_pa_q[2] <= in_n[0] * in_t[1];
      s1_pb_q[2] <= in_n[1] * in_t[0];
      s1_n_q     <= in_n;
      s1_t_q     <= in_t;
      s1_w_q     <= in_w;
      s1_sb_q    <= {ray_dir_i, outside_index_i, random_draw_i};

      for (int k = 0; k < 3; k++) begin
        s2_b_q[k]  <= s1_pa_q[k] - s1_pb_q[k];
        s2_tw_q[k] <= s1_t_q[k] * s1_w_q[0];
        s2_nw_q[k] <= s1_n_q[k] * s1_w_q[2];
      end
      s2_w1_q <= s1_w_q[1];
      s2_sb_q <= s1_sb_q;

      for (int k = 0; k < 3; k++) begin
        s3_bw_q[k] <= s2_b_q[k] * s2_w1_q;
        s3_tn_q[k] <= s2_tw_q[k] + s2_nw_q[k];
      end
      s3_sb_q <= s2_sb_q;

      for (int k = 0; k < 3; k++) begin
        s4_p_q[k] <= (PPW'(s3_tn_q[k]) <<< FRAC_BITS) + PPW'(s3_bw_q[k]);
      end
      s4_sb_q <= s3_sb_q;

      for (int k = 0; k < 3; k++) begin
        s5_m_q[k]   <= PW'(s4_p_q[k][PW] ? -s4_p_q[k] : s4_p_q[k]);
        s5_neg_q[k] <= s4_p_q[k][PW];
      end
      s5_sb_q <= s4_sb_q;

      s6_m_q   <= s5_m_q;
      s6_mx_q  <= mx_all;
      s6_neg_q <= s5_neg_q;
      s6_sb_q  <= s5_sb_q;
    end
  end

  // ---------------- normalize so the largest magnitude has its top bit set ----------------
  logic          nm_v_q   [NSH];
  logic [PW-1:0] nm_m_q   [NSH][3];
  logic [PW-1:0] nm_mx_q  [NSH];
  logic [2:0]    nm_neg_q [NSH];
  logic [79:0]   nm_sb_q  [NSH];

  for (genvar i = 0; i < NSH; i++) begin : g_norm
    localparam int unsigned SH = 1 << (NSH - 1 - i);
    logic          p_v;
    logic [PW-1:0] p_m [3];
    logic [PW-1:0] p_mx;
    logic [2:0]    p_neg;
    logic [79:0]   p_sb;
    logic          sft;

    if (i == 0) begin : g_first
      assign p_v   = s6_v_q;
      assign p_m   = s6_m_q;
      assign p_mx  = s6_mx_q;
      assign p_neg = s6_neg_q;
      assign p_sb  = s6_sb_q;
    end else begin : g_next
      assign p_v   = nm_v_q[i-1];
      assign p_m   = nm_m_q[i-1];
      assign p_mx  = nm_mx_q[i-1];
      assign p_neg = nm_neg_q[i-1];
      assign p_sb  = nm_sb_q[i-1];
    end

    assign sft = (p_mx[PW-1 -: SH] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nm_v_q[i] <= 1'b0;
      end else if (pipe_en) begin
        nm_v_q[i] <= p_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        for (int k = 0; k < 3; k++) begin
          nm_m_q[i][k] <= sft ? (p_m[k] << SH) : p_m[k];
        end
        nm_mx_q[i]  <= sft ? (p_mx << SH) : p_mx;
        nm_neg_q[i] <= p_neg;
        nm_sb_q[i]  <= p_sb;
      end
    end
  end

  // ---------------- dot product and squared length ----------------
  logic [29:0]        m30 [3];
  logic signed [30:0] pk  [3];
  logic signed [15:0] dk  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m30[k] = nm_m_q[NSH-1][k][PW-1 -: 30];
      pk[k]  = nm_neg_q[NSH-1][k] ? -$signed({1'b0, m30[k]}) : $signed({1'b0, m30[k]});
      dk[k]  = $signed(nm_sb_q[NSH-1][32+16*k +: 16]);
    end
  end

  logic               s7_v_q;
  logic signed [46:0] s7_dp_q [3];
  logic [59:0]        s7_sq_q [3];
  logic               s7_zero_q;
  logic [31:0]        s7_es_q;

  logic               s8_v_q;
  logic signed [48:0] s8_dot_q;
  logic [61:0]        s8_sq_q;
  logic               s8_zero_q;
  logic [31:0]        s8_es_q;

  logic        s9_v_q;
  logic [47:0] s9_adot_q;
  logic [61:0] s9_sq_q;
  logic        s9_zero_q;
  logic [31:0] s9_es_q;

  logic signed [48:0] dot_neg;
  assign dot_neg = -s8_dot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
      s9_v_q <= 1'b0;
    end else if (pipe_en) begin
      s7_v_q <= nm_v_q[NSH-1];
      s8_v_q <= s7_v_q;
      s9_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        s7_dp_q[k] <= dk[k] * pk[k];
        s7_sq_q[k] <= m30[k] * m30[k];
      end
      // a zero vector never gets its top bit set
      s7_zero_q <= !nm_mx_q[NSH-1][PW-1];
      s7_es_q   <= nm_sb_q[NSH-1][31:0];

      s8_dot_q  <= s7_dp_q[0] + s7_dp_q[1] + s7_dp_q[2];
      s8_sq_q   <= 62'(s7_sq_q[0]) + 62'(s7_sq_q[1]) + 62'(s7_sq_q[2]);
      s8_zero_q <= s7_zero_q;
      s8_es_q   <= s7_es_q;

      s9_adot_q <= 48'(s8_dot_q[48] ? dot_neg : s8_dot_q);
      s9_sq_q   <= s8_sq_q;
      s9_zero_q <= s8_zero_q;
      s9_es_q   <= s8_es_q;
    end
  end

  // ---------------- vector length ----------------
  logic        nrm_v;
  logic [30:0] nrm_root;
  logic [80:0] nrm_side;

  fnms_isqrt #(
    .XW(62),
    .SW(81)
  ) u_norm_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s9_v_q),
    .x_i     (s9_sq_q),
    .side_i  ({s9_adot_q, s9_zero_q, s9_es_q}),
    .valid_o (nrm_v),
    .root_o  (nrm_root),
    .side_o  (nrm_side)
  );

  // ---------------- cosine of incidence ----------------
  logic [CNW-1:0] cn_num;
  logic           cn_sat;
  assign cn_num = CNW'(nrm_side[80:33]) << CSH;
  assign cn_sat = (cn_num >> CW) >= CNW'(nrm_root);

  logic          cd_v;
  logic [CW-1:0] cd_q;
  logic [33:0]   cd_side;

  fnms_div #(
    .NW(CNW),
    .DW(31),
    .QB(CW),
    .SW(34)
  ) u_cos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (nrm_v),
    .num_i   (cn_num),
    .den_i   (nrm_root),
    .side_i  ({nrm_side[32], cn_sat, nrm_side[31:0]}),
    .valid_o (cd_v),
    .quot_o  (cd_q),
    .side_o  (cd_side)
  );

  logic          s10_v_q;
  logic [CW-1:0] s10_cosi_q;
  logic [31:0]   s10_es_q;

  logic           s11_v_q;
  logic [2*CW-1:0] s11_csq_q;
  logic [CW-1:0]  s11_cosi_q;
  logic [31:0]    s11_es_q;

  logic [CW-1:0] cosi_n;
  always_comb begin
    priority if (cd_side[33]) begin
      // zero perturbed normal reads as grazing
      cosi_n = '0;
    end else if (cd_side[32] || (cd_q > fnms_pkg::ONE_Q24)) begin
      cosi_n = fnms_pkg::ONE_Q24;
    end else begin
      cosi_n = cd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_v_q <= 1'b0;
      s11_v_q <= 1'b0;
    end else if (pipe_en) begin
      s10_v_q <= cd_v;
      s11_v_q <= s10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s10_cosi_q <= cosi_n;
      s10_es_q   <= cd_side[31:0];
      s11_csq_q  <= s10_cosi_q * s10_cosi_q;
      s11_cosi_q <= s10_cosi_q;
      s11_es_q   <= s10_es_q;
    end
  end

  // ---------------- sine of incidence ----------------
  logic          sn_v;
  logic [CW-1:0] sn_root;
  logic [56:0]   sn_side;

  fnms_isqrt #(
    .XW(SQW),
    .SW(57)
  ) u_sin_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s11_v_q),
    .x_i     (fnms_pkg::ONE_Q48 - s11_csq_q),
    .side_i  ({s11_cosi_q, s11_es_q}),
    .valid_o (sn_v),
    .root_o  (sn_root),
    .side_o  (sn_side)
  );

  logic        s12_v_q;
  logic [40:0] s12_num_q;
  logic [56:0] s12_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_v_q <= 1'b0;
    end else if (pipe_en) begin
      s12_v_q <= sn_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s12_num_q  <= sn_side[31:16] * sn_root;
      s12_side_q <= sn_side;
    end
  end

  // ---------------- transmitted sine ----------------
  logic sd_sat_n;
  assign sd_sat_n = (s12_num_q >> CW) >= 41'(material_index_q);

  logic          sd_v;
  logic [CW-1:0] sd_q;
  logic [57:0]   sd_side;

  fnms_div #(
    .NW(41),
    .DW(16),
    .QB(CW),
    .SW(58)
  ) u_sint_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s12_v_q),
    .num_i   (s12_num_q),
    .den_i   (material_index_q),
    .side_i  ({s12_side_q, sd_sat_n}),
    .valid_o (sd_v),
    .quot_o  (sd_q),
    .side_o  (sd_side)
  );

  logic        s13_v_q;
  logic [47:0] s13_ssq_q;
  logic [56:0] s13_side_q;
  logic        s13_tir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s13_v_q <= 1'b0;
    end else if (pipe_en) begin
      s13_v_q <= sd_v;
    end
  end

  // a zero material index also lands in the saturated case
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s13_ssq_q  <= sd_q[CW-2:0] * sd_q[CW-2:0];
      s13_tir_q  <= sd_side[0] || sd_q[CW-1];
      s13_side_q <= sd_side[57:1];
    end
  end

  // ---------------- transmitted cosine ----------------
  logic          cs_v;
  logic [CW-1:0] cs_root;
  logic [57:0]   cs_side;

  fnms_isqrt #(
    .XW(SQW),
    .SW(58)
  ) u_cost_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s13_v_q),
    .x_i     (fnms_pkg::ONE_Q48 - SQW'(s13_ssq_q)),
    .side_i  ({s13_side_q, s13_tir_q}),
    .valid_o (cs_v),
    .root_o  (cs_root),
    .side_o  (cs_side)
  );

  // ---------------- Fresnel terms ----------------
  logic [CW-1:0] cs_cosi;
  logic [15:0]   cs_etai;
  assign cs_cosi = cs_side[57:33];
  assign cs_etai = cs_side[32:17];

  logic        s14_v_q;
  logic [40:0] s14_a_q;
  logic [40:0] s14_b_q;
  logic [40:0] s14_c_q;
  logic [40:0] s14_e_q;
  logic [15:0] s14_draw_q;
  logic        s14_tir_q;

  logic        s15_v_q;
  logic [40:0] s15_ns_q;
  logic [41:0] s15_ds_q;
  logic [40:0] s15_np_q;
  logic [41:0] s15_dp_q;
  logic [15:0] s15_draw_q;
  logic        s15_tir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s14_v_q <= 1'b0;
      s15_v_q <= 1'b0;
    end else if (pipe_en) begin
      s14_v_q <= cs_v;
      s15_v_q <= s14_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s14_a_q    <= material_index_q * cs_cosi;
      s14_b_q    <= cs_etai * cs_root;
      s14_c_q    <= cs_etai * cs_cosi;
      s14_e_q    <= material_index_q * cs_root;
      s14_draw_q <= cs_side[16:1];
      s14_tir_q  <= cs_side[0];

      s15_ns_q   <= (s14_a_q > s14_b_q) ? s14_a_q - s14_b_q : s14_b_q - s14_a_q;
      s15_ds_q   <= 42'(s14_a_q) + 42'(s14_b_q);
      s15_np_q   <= (s14_c_q > s14_e_q) ? s14_c_q - s14_e_q : s14_e_q - s14_c_q;
      s15_dp_q   <= 42'(s14_c_q) + 42'(s14_e_q);
      s15_draw_q <= s14_draw_q;
      s15_tir_q  <= s14_tir_q;
    end
  end

  logic           rs_v;
  logic [RBW-1:0] rs_q;
  logic [17:0]    rs_side;
  logic           rp_v;
  logic [RBW-1:0] rp_q;
  logic           rp_side;

  fnms_div #(
    .NW(63),
    .DW(42),
    .QB(RBW),
    .SW(18)
  ) u_rs_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s15_v_q),
    .num_i   (63'(s15_ns_q) << 22),
    .den_i   (s15_ds_q),
    .side_i  ({s15_ds_q == '0, s15_draw_q, s15_tir_q}),
    .valid_o (rs_v),
    .quot_o  (rs_q),
    .side_o  (rs_side)
  );

  fnms_div #(
    .NW(63),
    .DW(42),
    .QB(RBW),
    .SW(1)
  ) u_rp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s15_v_q),
    .num_i   (63'(s15_np_q) << 22),
    .den_i   (s15_dp_q),
    .side_i  (s15_dp_q == '0),
    .valid_o (rp_v),
    .quot_o  (rp_q),
    .side_o  (rp_side)
  );

  // empty denominator means ratio one
  logic [RBW-1:0] rs_val;
  logic [RBW-1:0] rp_val;
  assign rs_val = rs_side[17] ? fnms_pkg::RATIO_ONE : rs_q;
  assign rp_val = rp_side ? fnms_pkg::RATIO_ONE : rp_q;

  logic             s16_v_q;
  logic [2*RBW-1:0] s16_rs2_q;
  logic [2*RBW-1:0] s16_rp2_q;
  logic [15:0]      s16_draw_q;
  logic             s16_tir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s16_v_q <= 1'b0;
    end else if (pipe_en) begin
      s16_v_q <= rs_v && rp_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s16_rs2_q  <= rs_val * rs_val;
      s16_rp2_q  <= rp_val * rp_val;
      s16_draw_q <= rs_side[16:1];
      s16_tir_q  <= rs_side[0];
    end
  end

  // ---------------- reflectance and branch choice ----------------
  logic [2*RBW:0] kr_sum;
  logic [17:0]    kr_raw;
  logic [16:0]    kr_n;
  assign kr_sum = (2*RBW+1)'(s16_rs2_q) + (2*RBW+1)'(s16_rp2_q);
  assign kr_raw = kr_sum[2*RBW -: 18];

  always_comb begin
    priority if (s16_tir_q) begin
      kr_n = fnms_pkg::KR_ONE;
    end else if (kr_raw > 18'(fnms_pkg::KR_ONE)) begin
      kr_n = fnms_pkg::KR_ONE;
    end else begin
      kr_n = kr_raw[16:0];
    end
  end

  logic [16:0] out_kr_q;
  logic        out_tir_q;
  logic        out_choose_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= s16_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_kr_q     <= kr_n;
      out_tir_q    <= s16_tir_q;
      out_choose_q <= {1'b0, s16_draw_q} <= kr_n;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign reflectance_o      = out_kr_q;
  assign total_internal_o   = out_tir_q;
  assign choose_reflected_o = out_choose_q;

  a_tir_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_internal_o |->
      reflectance_o == fnms_pkg::KR_ONE && choose_reflected_o)
    else $error("total internal reflection without full reflectance");

  a_kr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= fnms_pkg::KR_ONE)
    else $error("reflectance above one");

  a_one_reflects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reflectance_o == fnms_pkg::KR_ONE |-> choose_reflected_o)
    else $error("full reflectance chose the refract branch");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reflectance_o))
    else $error("stalled result changed");

endmodule

[verif/fresnel_normal_mapped_select_top_test.sv]
`timescale 1ns / 1ps

module fresnel_normal_mapped_select_top_test;

  typedef struct packed {
    logic        choose_reflected;
    logic [16:0] reflectance;
    logic        total_internal;
  } shade_t;

  function automatic longint unsigned isqrt_u64(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned fresnel_ratio(longint unsigned x, longint unsigned y);
    longint unsigned num, den;
    num = (x > y) ? x - y : y - x;
    den = x + y;
    if (den == 0) return 64'd1 << 22;
    return (num << 22) / den;
  endfunction

  function automatic shade_t predict_fresnel(logic [47:0] nv, logic [47:0] tv,
                                             logic [47:0] sv, logic [47:0] dv,
                                             logic [15:0] etai16, logic [15:0] draw16,
                                             logic [15:0] etat16);
    longint n[3], t[3], d[3], b[3], w[3], p[3];
    longint unsigned m[3];
    longint unsigned mx, sq, cosi, kr, etai, etat, sin_i, sint, cost, rs, rp, adot, nrm;
    longint dot, scale, pk;
    bit tir;
    shade_t r;
    mx = 0; sq = 0; cosi = 0; kr = 0; dot = 0; tir = 0;
    scale = longint'(1) <<< fnms_pkg::FRAC_BITS_DEF;
    etai = etai16;
    etat = etat16;
    for (int k = 0; k < 3; k++) begin
      n[k] = longint'($signed(nv[16*k +: 16]));
      t[k] = longint'($signed(tv[16*k +: 16]));
      d[k] = longint'($signed(dv[16*k +: 16]));
      w[k] = 2 * longint'({48'd0, sv[16*k +: 16]}) - 65536;
    end
    b[0] = n[1] * t[2] - n[2] * t[1];
    b[1] = n[2] * t[0] - n[0] * t[2];
    b[2] = n[0] * t[1] - n[1] * t[0];
    for (int k = 0; k < 3; k++) begin
      p[k] = t[k] * w[0] * scale + b[k] * w[1] + n[k] * w[2] * scale;
      m[k] = (p[k] < 0) ? longint'(-p[k]) : longint'(p[k]);
      if (m[k] > mx) mx = m[k];
    end
    // a zero perturbed normal stays grazing
    if (mx != 0) begin
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int k = 0; k < 3; k++) m[k] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int k = 0; k < 3; k++) m[k] <<= 1;
      end
      for (int k = 0; k < 3; k++) begin
        pk = (p[k] < 0) ? -longint'(m[k]) : longint'(m[k]);
        dot += d[k] * pk;
        sq += m[k] * m[k];
      end
      nrm = isqrt_u64(sq);
      adot = (dot < 0) ? longint'(-dot) : longint'(dot);
      cosi = (adot << (24 - fnms_pkg::FRAC_BITS_DEF)) / nrm;
      if (cosi > (64'd1 << 24)) cosi = 64'd1 << 24;
    end
    if (etat == 0) begin
      tir = 1;
    end else begin
      sin_i = isqrt_u64((64'd1 << 48) - cosi * cosi);
      sint = etai * sin_i / etat;
      if (sint >= (64'd1 << 24)) begin
        tir = 1;
      end else begin
        cost = isqrt_u64((64'd1 << 48) - sint * sint);
        rs = fresnel_ratio(etat * cosi, etai * cost);
        rp = fresnel_ratio(etai * cosi, etat * cost);
        kr = (rs * rs + rp * rp) >> 29;
        if (kr > 65536) kr = 65536;
      end
    end
    if (tir) kr = 65536;
    r.choose_reflected = (longint'({48'd0, draw16}) <= longint'(kr));
    r.reflectance = kr[16:0];
    r.total_internal = tir;
    return r;
  endfunction

  class fresnel_ledger;
    shade_t pending_shades[$];
    logic [15:0] etat = fnms_pkg::MAT_INDEX_RST;
    int errors = 0;

    function void note_ray(logic [47:0] nv, logic [47:0] tv, logic [47:0] sv,
                           logic [47:0] dv, logic [15:0] etai, logic [15:0] draw);
      pending_shades.push_back(predict_fresnel(nv, tv, sv, dv, etai, draw, etat));
    endfunction

    function void check_result(logic cr, logic [16:0] kr, logic tir);
      shade_t e;
      if (pending_shades.size() == 0) begin
        $display("%0t: result with none expected: cr=%0d kr=%0d tir=%0d",
                 $time, cr, kr, tir);
        errors++;
        return;
      end
      e = pending_shades.pop_front();
      if (cr !== e.choose_reflected) begin
        $display("%0t: choose_reflected expected %0d actual %0d", $time,
                 e.choose_reflected, cr);
        errors++;
      end
      if (kr !== e.reflectance) begin
        $display("%0t: reflectance expected %0d actual %0d", $time, e.reflectance, kr);
        errors++;
      end
      if (tir !== e.total_internal) begin
        $display("%0t: total_internal expected %0d actual %0d", $time,
                 e.total_internal, tir);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [47:0] normal_vec_i = '0;
  logic [47:0] tangent_vec_i = '0;
  logic [47:0] map_sample_i = '0;
  logic [47:0] ray_dir_i = '0;
  logic [15:0] outside_index_i = 16'd4096;
  logic [15:0] random_draw_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        choose_reflected_o;
  logic [16:0] reflectance_o;
  logic        total_internal_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  fresnel_ledger ledger = new();
  int send_idle_pct = 7;
  int recv_idle_pct = 78;
  bit hold_req = 0;
  bit hold_on = 0;

  fresnel_normal_mapped_select_top uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // long receiver hold so the pipeline fills and backs up the input
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_on = 1;
    repeat (600) @(posedge clk_i);
    hold_on = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      ledger.check_result(choose_reflected_o, reflectance_o, total_internal_o);
    out_ready_i <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [47:0] unit_vec();
    real x, y, z, l;
    logic [15:0] c[3];
    x = real'(int'($urandom_range(2000))) - 1000.0;
    y = real'(int'($urandom_range(2000))) - 1000.0;
    z = real'(int'($urandom_range(2000))) - 1000.0;
    l = $sqrt(x * x + y * y + z * z);
    if (l < 1.0) return pack3(16'd0, 16'd0, 16'd16384);
    c[0] = 16'($rtoi(x / l * 16383.0));
    c[1] = 16'($rtoi(y / l * 16383.0));
    c[2] = 16'($rtoi(z / l * 16383.0));
    return pack3(c[0], c[1], c[2]);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(16'hffff)), $urandom()};
  endfunction

  task automatic send_ray(logic [47:0] nv, logic [47:0] tv, logic [47:0] sv,
                          logic [47:0] dv, logic [15:0] etai, logic [15:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    normal_vec_i <= nv;
    tangent_vec_i <= tv;
    map_sample_i <= sv;
    ray_dir_i <= dv;
    outside_index_i <= etai;
    random_draw_i <= draw;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_ray(nv, tv, sv, dv, etai, draw);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (ledger.pending_shades.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_material(logic [15:0] v);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    ledger.etat = v;
    @(posedge clk_i);
  endtask

  task automatic random_rays(int count);
    logic [47:0] nv, tv, dv;
    logic [15:0] etai;
    repeat (count) begin
      if ($urandom_range(99) < 80) begin
        nv = unit_vec();
        tv = unit_vec();
        dv = unit_vec();
      end else begin
        nv = rand48();
        tv = rand48();
        dv = rand48();
      end
      etai = ($urandom_range(1)) ? 16'($urandom_range(8192, 4096))
                                 : 16'($urandom_range(65535, 4096));
      send_ray(nv, tv, rand48(), dv, etai, 16'($urandom_range(65535)));
    end
  endtask

  localparam logic [47:0] N_Z = 48'h4000_0000_0000;
  localparam logic [47:0] T_X = 48'h0000_0000_4000;

  initial begin
    logic [15:0] mats[5];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // flat map sample gives a zero perturbed normal
    send_ray(N_Z, T_X, {3{16'h8000}}, 48'hc000_0000_0000, 16'd4096, 16'd0);
    // head-on along the geometric normal
    send_ray(N_Z, T_X, {16'hffff, 16'h8000, 16'h8000}, 48'hc000_0000_0000,
             16'd4096, 16'd65535);
    send_ray(N_Z, T_X, {16'hffff, 16'h8000, 16'h8000}, 48'h4000_0000_0000,
             16'd6144, 16'd1000);
    // non-unit ray, cosine capped at one
    send_ray(N_Z, T_X, {16'hffff, 16'h8000, 16'h8000}, 48'h8000_0000_0000,
             16'd4096, 16'd2000);
    // grazing ray from a dense medium: total internal reflection
    send_ray(N_Z, T_X, {16'hffff, 16'h8000, 16'h8000}, 48'h0000_0000_4000,
             16'd65535, 16'd65535);
    send_ray(N_Z, T_X, {16'hffff, 16'h8000, 16'h8000}, 48'h0000_2000_3000,
             16'd12000, 16'd30000);
    // tangent and bitangent weights at their extremes
    send_ray(N_Z, T_X, {16'h8000, 16'h0000, 16'hffff}, 48'h0000_0000_c000,
             16'd4096, 16'd500);
    send_ray(N_Z, T_X, {16'h0000, 16'hffff, 16'h0000}, 48'h0000_4000_0000,
             16'd5000, 16'd40000);
    send_ray('1, '1, '1, '1, 16'hffff, 16'hffff);
    send_ray('0, '0, '0, '0, 16'd4096, 16'd0);
    send_ray({3{16'h8000}}, {3{16'h7fff}}, '0, {3{16'h8000}}, 16'd4097, 16'd1);
    send_ray({3{16'h7fff}}, {3{16'h8000}}, '1, {3{16'h7fff}}, 16'd8000, 16'd32768);
    random_rays(8);
    drain();

    mats = '{16'd4096, 16'd65535, 16'($urandom_range(65535, 4096)), 16'd6144,
             16'($urandom_range(9000, 4096))};
    for (int ph = 0; ph < 5; ph++) begin
      write_material(mats[ph]);
      case (ph % 3)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 2) hold_req = 1;
      random_rays(276);
      drain();
    end

    if (ledger.errors == 0 && ledger.pending_shades.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (ledger.pending_shades.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 ledger.pending_shades.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
